// ----- rtl/pcpfl_pkg.sv -----
// Package for the per-CPU page free list allocator.
// Holds the channel payload types, the command and status codes and the register map.
// Depends on nothing; pcpfl_ctrl, pcpfl_dp, the top level, the checker and the testbench import it.
package pcpfl_pkg;

	localparam int ADDR_W = 32;
	localparam int CPU_ID_W = 3;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MEM_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEM_TOP = 1'd1;

	localparam logic [ADDR_W-1:0] MEM_BASE_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] MEM_TOP_RST = 32'h8800_0000;

	typedef struct packed {
		logic command;
		logic [CPU_ID_W-1:0] cpu_id;
		logic [ADDR_W-1:0] page_addr;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] alloc_addr;
		logic [STATUS_W-1:0] status;
		logic stolen;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [ADDR_W-1:0] wdata;
	} cfg_t;

	typedef struct packed {
		logic capture;
		logic push;
		logic pop_rd;
		logic pop_wr;
		logic rsp_ld;
	} ctl_t;

	typedef struct packed {
		logic is_free;
		logic free_ok;
		logic any_src;
	} sts_t;

endpackage

// ----- rtl/pcpfl_chan_if.sv -----
// Valid/ready channel interface used for the request, response and register write channels.
// The payload type is a parameter; the payload structs come from pcpfl_pkg.
interface pcpfl_chan_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pcpfl_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the per-page next links; depends on nothing.
module pcpfl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/pcpfl_ctrl.sv -----
// Controller of the allocator: sequences accept, execute and pop, and owns the response valid.
// Depends on pcpfl_pkg for the control and status structs.
module pcpfl_ctrl
	import pcpfl_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	input sts_t sts,
	output ctl_t ctl
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_POP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic rsp_valid_q;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				if (req_valid && req_ready) begin
					ctl.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_free) begin
					ctl.push = sts.free_ok;
					ctl.rsp_ld = 1'b1;
					state_d = ST_IDLE;
				end else if (sts.any_src) begin
					ctl.pop_rd = 1'b1;
					state_d = ST_POP;
				end else begin
					ctl.rsp_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP: begin
				ctl.pop_wr = 1'b1;
				ctl.rsp_ld = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
endmodule

// ----- rtl/pcpfl_dp.sv -----
// Datapath of the allocator: base and top registers, list heads, free address checks,
// steal selection, the next-link RAM and the response register.
// Depends on pcpfl_pkg and pcpfl_ram.
module pcpfl_dp
	import pcpfl_pkg::*;
#(
	parameter int NUM_CPUS = 8,
	parameter int PAGE_SHIFT = 12,
	parameter int MAX_PAGES = 32768
) (
	input logic clk,
	input logic arst_n,
	input ctl_t ctl,
	input req_t req_data,
	input logic cfg_we,
	input cfg_t cfg_data,
	output sts_t sts,
	output rsp_t rsp_data
);
	localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int IDX_W = $clog2(MAX_PAGES);
	localparam int HI_W = ADDR_W + 1 - PAGE_SHIFT;
	localparam logic [ADDR_W:0] PG_MASK = (ADDR_W + 1)'((33'd1 << PAGE_SHIFT) - 33'd1);
	localparam logic [ADDR_W:0] BASE_RST = ({1'b0, MEM_BASE_RST} + PG_MASK) & ~PG_MASK;

	logic [ADDR_W:0] base_q;
	logic [ADDR_W-1:0] top_q;

	logic cmd_q;
	logic [CPU_ID_W-1:0] cpu_q;
	logic [ADDR_W-1:0] pa_q;

	logic [NUM_CPUS-1:0] head_vld_q;
	logic [IDX_W-1:0] head_idx_q [NUM_CPUS];

	logic [CPU_W-1:0] src_q;
	logic stolen_q;
	logic [IDX_W-1:0] pop_idx_q;

	logic [6:0] cpu_ext;
	logic [CPU_W-1:0] cpu_ix;
	logic cpu_ok;
	logic own_ok;
	logic [CPU_W-1:0] low_ix;
	logic [CPU_W-1:0] src_ix;
	logic [CPU_W-1:0] sel_ix;
	logic [IDX_W:0] head_rd;
	logic [ADDR_W:0] diff;
	logic free_ok;
	logic [IDX_W-1:0] new_idx;
	logic [IDX_W:0] link_rdata;
	logic [ADDR_W:0] addr_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			top_q <= MEM_TOP_RST;
		end else if (cfg_we) begin
			unique case (cfg_data.index)
				REG_MEM_BASE: base_q <= ({1'b0, cfg_data.wdata} + PG_MASK) & ~PG_MASK;
				REG_MEM_TOP: top_q <= cfg_data.wdata;
				default: top_q <= top_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= req_data.command;
			cpu_q <= req_data.cpu_id;
			pa_q <= req_data.page_addr;
		end
	end

	assign cpu_ext = 7'(cpu_q);
	assign cpu_ix = cpu_ext[CPU_W-1:0];
	assign cpu_ok = cpu_ext < 7'(NUM_CPUS);
	assign own_ok = cpu_ok && head_vld_q[cpu_ix];

	always_comb begin
		low_ix = '0;
		for (int c = NUM_CPUS - 1; c >= 0; c--) begin
			if (head_vld_q[c]) begin
				low_ix = CPU_W'(c);
			end
		end
	end

	assign src_ix = own_ok ? cpu_ix : low_ix;
	assign sel_ix = (cmd_q == CMD_FREE) ? cpu_ix : src_ix;
	assign head_rd = {head_vld_q[sel_ix], head_idx_q[sel_ix]};

	assign diff = {1'b0, pa_q} - base_q;
	assign new_idx = diff[PAGE_SHIFT +: IDX_W];
	assign free_ok = cpu_ok
		&& (pa_q[PAGE_SHIFT-1:0] == '0)
		&& !({1'b0, pa_q} < base_q)
		&& (pa_q < top_q)
		&& (diff[ADDR_W:PAGE_SHIFT] < HI_W'(MAX_PAGES));

	assign sts.is_free = (cmd_q == CMD_FREE);
	assign sts.free_ok = free_ok;
	assign sts.any_src = |head_vld_q;

	pcpfl_ram #(
		.WIDTH(IDX_W + 1),
		.DEPTH(MAX_PAGES)
	) u_links (
		.clk(clk),
		.we(ctl.push),
		.waddr(new_idx),
		.wdata(head_rd),
		.re(ctl.pop_rd),
		.raddr(head_rd[IDX_W-1:0]),
		.rdata(link_rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.pop_rd) begin
			src_q <= src_ix;
			stolen_q <= !own_ok;
			pop_idx_q <= head_rd[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= '0;
		end else if (ctl.push) begin
			head_vld_q[cpu_ix] <= 1'b1;
		end else if (ctl.pop_wr) begin
			head_vld_q[src_q] <= link_rdata[IDX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			head_idx_q[cpu_ix] <= new_idx;
		end else if (ctl.pop_wr) begin
			head_idx_q[src_q] <= link_rdata[IDX_W-1:0];
		end
	end

	assign addr_sum = base_q + ((ADDR_W + 1)'(pop_idx_q) << PAGE_SHIFT);

	always_ff @(posedge clk) begin
		if (ctl.rsp_ld) begin
			if (ctl.pop_wr) begin
				rsp_data.alloc_addr <= addr_sum[ADDR_W-1:0];
				rsp_data.status <= ST_OK;
				rsp_data.stolen <= stolen_q;
			end else if (cmd_q == CMD_FREE) begin
				rsp_data.alloc_addr <= '0;
				rsp_data.status <= free_ok ? ST_OK : ST_BAD_FREE;
				rsp_data.stolen <= 1'b0;
			end else begin
				rsp_data.alloc_addr <= '0;
				rsp_data.status <= ST_OOM;
				rsp_data.stolen <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/per_cpu_page_free_list_allocator.sv -----
// Top level of the per-CPU page free list allocator with stealing.
// Depends on pcpfl_pkg, pcpfl_chan_if, pcpfl_ctrl, pcpfl_dp and pcpfl_ram.
//
// Usage:
// The req channel carries one item per request: an allocate or a free for one CPU.
// Every item gives exactly one item on the rsp channel, in order.
// The cfg channel writes mem_base (index 0) or mem_top (index 1); it is always ready
// and must only be used while no request is in flight.
// On a free, the request is captured, then the address is checked, the page is pushed
// if the address is good and the response register is loaded.
// An allocate that finds a page goes on through the pop state, because the next link of the popped page
// comes from the link RAM, whose read is registered. An allocate that finds every list
// empty is answered from the execute state.
// One item is worked on at a time; the next one is taken once the response register is
// empty or is being emptied, so a stalled receiver holds off new requests.
// Reset empties every list and loads the default base and top; the link RAM needs
// no clearing.
module per_cpu_page_free_list_allocator
	import pcpfl_pkg::*;
#(
	parameter int NUM_CPUS = 8,
	parameter int PAGE_SHIFT = 12,
	parameter int MAX_PAGES = 32768
) (
	input logic clk,
	input logic arst_n,
	pcpfl_chan_if.sink req,
	pcpfl_chan_if.source rsp,
	pcpfl_chan_if.sink cfg
);
	ctl_t ctl;
	sts_t sts;
	rsp_t rsp_data;

	assign cfg.ready = 1'b1;

	pcpfl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.sts(sts),
		.ctl(ctl)
	);

	pcpfl_dp #(
		.NUM_CPUS(NUM_CPUS),
		.PAGE_SHIFT(PAGE_SHIFT),
		.MAX_PAGES(MAX_PAGES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.req_data(req.data),
		.cfg_we(cfg.valid && cfg.ready),
		.cfg_data(cfg.data),
		.sts(sts),
		.rsp_data(rsp_data)
	);

	assign rsp.data = rsp_data;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while another one is in flight");

	a_pop_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop_rd |=> (ctl.pop_wr && ctl.rsp_ld))
		else $error("link read not followed by the pop");

	a_rsp_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rsp_ld |-> !rsp.valid)
		else $error("response loaded over a pending one");
endmodule

// ----- sim/pcpfl_checker.sv -----
`timescale 1ns / 100ps
// Checker for the per-CPU page free list allocator: keeps its own copy of the free lists,
// predicts one response per accepted request and compares responses in order.
// Depends on pcpfl_pkg for the payload structs and the command, status and register codes.
module pcpfl_checker
	import pcpfl_pkg::*;
#(
	parameter int NUM_CPUS = 8,
	parameter int PAGE_SHIFT = 12,
	parameter int MAX_PAGES = 32768
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input cfg_t cfg_data,
	output int mismatch_count,
	output int pending_count
);

	localparam logic [ADDR_W:0] PAGE_MASK = (33'd1 << PAGE_SHIFT) - 33'd1;
	localparam int IDX_W = 15;

	logic [ADDR_W-1:0] base_reg;
	logic [ADDR_W-1:0] top_reg;
	logic [IDX_W:0] head_tab [NUM_CPUS];
	logic [IDX_W:0] link_tab [MAX_PAGES];
	rsp_t expected_rsps [$];
	int errors = 0;

	function automatic rsp_t serve_request(input req_t r);
		logic [ADDR_W:0] rb;
		logic [ADDR_W:0] offset;
		int src;
		int c;
		logic [IDX_W-1:0] idx;
		rsp_t res;
		rb = ({1'b0, base_reg} + PAGE_MASK) & ~PAGE_MASK;
		res = '0;
		if (r.command == CMD_FREE) begin
			if (r.cpu_id >= NUM_CPUS || ({1'b0, r.page_addr} & PAGE_MASK) != 0 ||
					{1'b0, r.page_addr} < rb || r.page_addr >= top_reg) begin
				res.status = ST_BAD_FREE;
			end else begin
				offset = ({1'b0, r.page_addr} - rb) >> PAGE_SHIFT;
				if (offset >= MAX_PAGES) begin
					res.status = ST_BAD_FREE;
				end else begin
					link_tab[offset[IDX_W-1:0]] = head_tab[r.cpu_id];
					head_tab[r.cpu_id] = {1'b1, offset[IDX_W-1:0]};
				end
			end
		end else begin
			src = NUM_CPUS;
			if (r.cpu_id < NUM_CPUS && head_tab[r.cpu_id][IDX_W]) begin
				src = r.cpu_id;
			end else begin
				for (c = 0; c < NUM_CPUS; c++) begin
					if (src == NUM_CPUS && c != r.cpu_id && head_tab[c][IDX_W])
						src = c;
				end
			end
			if (src == NUM_CPUS) begin
				res.status = ST_OOM;
			end else begin
				idx = head_tab[src][IDX_W-1:0];
				head_tab[src] = link_tab[idx];
				res.alloc_addr = ADDR_W'(rb + ({{(ADDR_W+1-IDX_W){1'b0}}, idx} << PAGE_SHIFT));
				res.stolen = (src != int'(r.cpu_id));
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			base_reg = MEM_BASE_RST;
			top_reg = MEM_TOP_RST;
			foreach (head_tab[i])
				head_tab[i] = '0;
			expected_rsps.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("response item with no request waiting: %p", rsp_data);
					errors++;
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp_data.alloc_addr !== exp_rsp.alloc_addr) begin
						$error("alloc_addr: expected %h, got %h", exp_rsp.alloc_addr,
							rsp_data.alloc_addr);
						errors++;
					end
					if (rsp_data.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status,
							rsp_data.status);
						errors++;
					end
					if (rsp_data.stolen !== exp_rsp.stolen) begin
						$error("stolen: expected %0d, got %0d", exp_rsp.stolen,
							rsp_data.stolen);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_MEM_BASE: base_reg = cfg_data.wdata;
					REG_MEM_TOP: top_reg = cfg_data.wdata;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				expected_rsps.push_back(serve_request(req_data));
		end
		mismatch_count <= errors;
		pending_count <= expected_rsps.size();
	end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and register stimulus, the verdict.
// Depends on pcpfl_pkg, pcpfl_chan_if, the allocator RTL and pcpfl_checker.
module testbench
	import pcpfl_pkg::*;
();

	localparam int NUM_CPUS = 8;
	localparam int PAGE_SHIFT = 12;
	localparam int MAX_PAGES = 32768;
	localparam logic [ADDR_W:0] PAGE_MASK = (33'd1 << PAGE_SHIFT) - 33'd1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcpfl_chan_if #(.payload_t(req_t)) req_ch ();
	pcpfl_chan_if #(.payload_t(rsp_t)) rsp_ch ();
	pcpfl_chan_if #(.payload_t(cfg_t)) cfg_ch ();

	int mismatch_count;
	int pending_count;
	int cycle_count = 0;
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int oom_seen = 0;
	int fresh_idx = 0;
	int npages = 0;
	logic [ADDR_W:0] cur_rb;
	logic [ADDR_W-1:0] cur_top;
	logic issued_cmds [$];
	logic [ADDR_W-1:0] held_pages [$];

	per_cpu_page_free_list_allocator #(
		.NUM_CPUS(NUM_CPUS),
		.PAGE_SHIFT(PAGE_SHIFT),
		.MAX_PAGES(MAX_PAGES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	pcpfl_checker #(
		.NUM_CPUS(NUM_CPUS),
		.PAGE_SHIFT(PAGE_SHIFT),
		.MAX_PAGES(MAX_PAGES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.req_data(req_ch.data),
		.rsp_valid(rsp_ch.valid),
		.rsp_ready(rsp_ch.ready),
		.rsp_data(rsp_ch.data),
		.cfg_valid(cfg_ch.valid),
		.cfg_ready(cfg_ch.ready),
		.cfg_data(cfg_ch.data),
		.mismatch_count(mismatch_count),
		.pending_count(pending_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver owns its hold counter; the stimulus only asks for a hold.
	always @(posedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served = hold_asked;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Sampled mid-cycle: an item seen here is accepted at the next rising edge.
	always @(negedge clk) begin
		if (rsp_ch.valid && rsp_ch.ready && issued_cmds.size() > 0) begin
			if (issued_cmds.pop_front() == CMD_ALLOC) begin
				if (rsp_ch.data.status == ST_OK)
					held_pages.push_back(rsp_ch.data.alloc_addr);
				else if (rsp_ch.data.status == ST_OOM)
					oom_seen++;
			end
		end
	end

	function automatic req_t mk_req(input logic cmd, input logic [CPU_ID_W-1:0] cpu,
			input logic [ADDR_W-1:0] addr);
		return req_t'{command: cmd, cpu_id: cpu, page_addr: addr};
	endfunction

	function automatic logic [ADDR_W-1:0] bad_address();
		logic [ADDR_W:0] a;
		case ($urandom_range(3))
			0: a = {1'b0, $urandom} | 33'($urandom_range(int'(PAGE_MASK), 1));
			1: begin
				if (cur_rb[ADDR_W])
					a = {1'b0, $urandom};
				else if (cur_rb != 0)
					a = (33'($urandom) % cur_rb) & ~PAGE_MASK;
				else
					a = {1'b0, cur_top};
			end
			2: a = {1'b0, cur_top};
			default: begin
				a = cur_rb + (33'(MAX_PAGES + $urandom_range(1023)) << PAGE_SHIFT);
				if (a >= {1'b0, cur_top})
					a = {1'b0, cur_top};
			end
		endcase
		return a[ADDR_W-1:0];
	endfunction

	function automatic req_t next_request();
		int pick;
		int slot;
		req_t r;
		pick = $urandom_range(99);
		r = mk_req(CMD_ALLOC, CPU_ID_W'($urandom_range(NUM_CPUS - 1)), $urandom);
		if (pick >= 45) begin
			r.command = CMD_FREE;
			if (pick >= 90) begin
				r.page_addr = bad_address();
			end else if (held_pages.size() > 0 &&
					(fresh_idx >= npages || $urandom_range(1))) begin
				slot = $urandom_range(held_pages.size() - 1);
				r.page_addr = held_pages[slot];
				held_pages.delete(slot);
			end else if (fresh_idx < npages) begin
				r.page_addr = ADDR_W'(cur_rb + (33'(fresh_idx) << PAGE_SHIFT));
				fresh_idx++;
			end else begin
				r.page_addr = bad_address();
			end
		end
		return r;
	endfunction

	task automatic send(input req_t item);
		if ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= item;
		do @(posedge clk); while (!req_ch.ready);
		issued_cmds.push_back(item.command);
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [ADDR_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= {reg_index, value};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] top);
		logic [ADDR_W:0] span;
		wait_idle();
		write_reg(REG_MEM_BASE, base);
		write_reg(REG_MEM_TOP, top);
		cur_rb = ({1'b0, base} + PAGE_MASK) & ~PAGE_MASK;
		cur_top = top;
		if (cur_rb >= {1'b0, top}) begin
			npages = 0;
		end else begin
			span = (({1'b0, top} - cur_rb) + PAGE_MASK) >> PAGE_SHIFT;
			npages = (span > MAX_PAGES) ? MAX_PAGES : int'(span);
		end
		held_pages.delete();
	endtask

	task automatic set_idling(input int send_pct, input int rsp_pct);
		sender_idle_pct = send_pct;
		stall_pct <= rsp_pct;
	endtask

	// Allocates until out of memory, so every list is empty and page indices can start over.
	task automatic drain_lists();
		int seen;
		seen = oom_seen;
		while (oom_seen == seen)
			send(mk_req(CMD_ALLOC, CPU_ID_W'($urandom_range(NUM_CPUS - 1)), $urandom));
		wait_idle();
		held_pages.delete();
		fresh_idx = 0;
	endtask

	task automatic run_phase(input int count, input int hold_at, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_asked <= hold_asked + 1;
			if (i == pause_at)
				wait_idle();
			send(next_request());
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(MEM_BASE_RST, MEM_TOP_RST);
		set_idling(0, 0);
		send(mk_req(CMD_ALLOC, 3'd0, 32'h0000_0000));
		send(mk_req(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF));
		send(mk_req(CMD_FREE, 3'd0, 32'h8000_0000));
		send(mk_req(CMD_FREE, 3'd7, 32'h87FF_F000));
		send(mk_req(CMD_FREE, 3'd3, 32'h8000_5000));
		send(mk_req(CMD_FREE, 3'd3, 32'h8000_6000));
		send(mk_req(CMD_FREE, 3'd1, 32'h8800_0000));
		send(mk_req(CMD_FREE, 3'd1, 32'h7FFF_F000));
		send(mk_req(CMD_FREE, 3'd2, 32'h8000_0001));
		send(mk_req(CMD_FREE, 3'd2, 32'h8000_0800));
		send(mk_req(CMD_FREE, 3'd4, 32'hFFFF_FFFF));
		send(mk_req(CMD_FREE, 3'd5, 32'h0000_0000));
		send(mk_req(CMD_ALLOC, 3'd3, 32'hFFFF_FFFF));
		send(mk_req(CMD_ALLOC, 3'd5, 32'h0000_0000));
		send(mk_req(CMD_ALLOC, 3'd3, 32'h8000_5000));
		send(mk_req(CMD_ALLOC, 3'd3, 32'h0000_0000));
		send(mk_req(CMD_ALLOC, 3'd6, 32'h0000_0000));
		// A double free makes the page link to itself; freeing it to an empty list ends the loop.
		send(mk_req(CMD_FREE, 3'd2, 32'h8000_9000));
		send(mk_req(CMD_FREE, 3'd2, 32'h8000_9000));
		send(mk_req(CMD_ALLOC, 3'd2, 32'h0000_0000));
		send(mk_req(CMD_FREE, 3'd4, 32'h8000_9000));
		send(mk_req(CMD_ALLOC, 3'd2, 32'h0000_0000));
		send(mk_req(CMD_ALLOC, 3'd4, 32'h0000_0000));
		send(mk_req(CMD_ALLOC, 3'd1, 32'h0000_0000));
		drain_lists();

		run_phase(350, 120, 240);
		drain_lists();

		set_config(32'h0000_0000, 32'hFFFF_FFFF);
		set_idling(70, 0);
		run_phase(350, -1, -1);
		drain_lists();

		set_config(32'h1234_5678, 32'h1234_E000);
		set_idling(0, 70);
		run_phase(350, -1, -1);
		// The base moves past the top of the address space while pages are still listed.
		set_config(32'hFFFF_F001, 32'hFFFF_FFFF);
		set_idling(32, 32);
		run_phase(150, -1, -1);
		drain_lists();

		set_config(32'hFFFF_FFFF, 32'h0000_0000);
		set_idling(0, 70);
		run_phase(60, -1, -1);
		drain_lists();

		set_config(32'h4000_0000, 32'h4002_0000);
		set_idling(32, 32);
		run_phase(400, 200, -1);
		drain_lists();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/pcpfl_pkg.sv
rtl/pcpfl_chan_if.sv
rtl/pcpfl_ram.sv
rtl/pcpfl_ctrl.sv
rtl/pcpfl_dp.sv
rtl/per_cpu_page_free_list_allocator.sv
sim/pcpfl_checker.sv
sim/testbench.sv
